[src/lqns_pkg.sv]
// Package for the loose quadtree node selector.
// Holds the field widths, register reset values, register indexes, the pipeline
// load struct and the table of level base indexes. It depends on nothing else.
package lqns_pkg;

   // Field widths
   localparam int COORD_W    = 24;
   localparam int HALF_W     = 23;
   localparam int SCALE_W    = 32;
   localparam int SHIFT_W    = 24;
   localparam int PROD_W     = SHIFT_W + SCALE_W;
   localparam int FRAC_W     = 24;
   localparam int LEVEL_W    = 3;
   localparam int CELL_W     = 7;
   localparam int NODE_W     = 15;
   localparam int IN_DATA_W  = 4 * COORD_W;
   localparam int OUT_DATA_W = LEVEL_W + 2 * CELL_W + NODE_W;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Defaults for the top-level parameters
   localparam int LEVEL_COUNT_DEFAULT = 8;
   localparam int GRID_BITS_DEFAULT   = 8;

   // Register reset values
   localparam logic [HALF_W-1:0]  HALF_SIZE_RESET = 23'd32768;
   localparam logic [SCALE_W-1:0] SCALE_RESET     = 32'd16711680;

   // Register indexes, taken from address bit 2
   typedef enum logic {
      REG_HALF_SIZE = 1'b0,
      REG_SCALE     = 1'b1
   } csr_reg_type;

   // Load enables of the five pipeline stages
   typedef struct packed {
      logic s1_load;
      logic s2_load;
      logic s3_load;
      logic s4_load;
      logic s5_load;
   } pipe_ctrl_type;

   // Index of the first node of a level: (4^level - 1) / 3.
   function automatic logic [NODE_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
      logic [NODE_W-1:0] base;
      case (lvl)
         3'd0:    base = 15'd0;
         3'd1:    base = 15'd1;
         3'd2:    base = 15'd5;
         3'd3:    base = 15'd21;
         3'd4:    base = 15'd85;
         3'd5:    base = 15'd341;
         3'd6:    base = 15'd1365;
         default: base = 15'd5461;
      endcase
      return base;
   endfunction

endpackage

[src/lqns_front.sv]
// First pipeline stage: bounds check against half_size and shift of the corners.
// Depends on lqns_pkg.
module lqns_front
   import lqns_pkg::*;
(
   input  logic                 clock,
   input  pipe_ctrl_type        ctrl,
   input  logic [HALF_W-1:0]    half_size,
   input  logic [COORD_W-1:0]   min_x,
   input  logic [COORD_W-1:0]   min_y,
   input  logic [COORD_W-1:0]   max_x,
   input  logic [COORD_W-1:0]   max_y,
   output logic                 outside,
   output logic [SHIFT_W-1:0]   shift_min_x,
   output logic [SHIFT_W-1:0]   shift_min_y,
   output logic [SHIFT_W-1:0]   shift_max_x,
   output logic [SHIFT_W-1:0]   shift_max_y
);

   localparam int EXT_W = COORD_W + 1;

   logic signed [EXT_W-1:0] half_pos;
   logic signed [EXT_W-1:0] half_neg;
   logic signed [EXT_W-1:0] min_x_ext, min_y_ext, max_x_ext, max_y_ext;

   logic                outside_in, outside_ff;
   logic [SHIFT_W-1:0]  sh_min_x_in, sh_min_y_in, sh_max_x_in, sh_max_y_in;
   logic [SHIFT_W-1:0]  sh_min_x_ff, sh_min_y_ff, sh_max_x_ff, sh_max_y_ff;

   // Shift a corner into the covered square; a negative sum gives zero.
   function automatic logic [SHIFT_W-1:0] shift_coord(input logic signed [EXT_W-1:0] c,
                                                      input logic signed [EXT_W-1:0] h);
      logic signed [EXT_W-1:0] sum;
      sum = c + h;
      return sum[EXT_W-1] ? '0 : sum[SHIFT_W-1:0];
   endfunction

   assign half_pos  = $signed({2'b00, half_size});
   assign half_neg  = -half_pos;
   assign min_x_ext = $signed({min_x[COORD_W-1], min_x});
   assign min_y_ext = $signed({min_y[COORD_W-1], min_y});
   assign max_x_ext = $signed({max_x[COORD_W-1], max_x});
   assign max_y_ext = $signed({max_y[COORD_W-1], max_y});

   // A box reaching past the covered square belongs to the root.
   assign outside_in = (min_x_ext < half_neg) || (max_x_ext > half_pos) ||
                       (min_y_ext < half_neg) || (max_y_ext > half_pos);

   assign sh_min_x_in = shift_coord(min_x_ext, half_pos);
   assign sh_min_y_in = shift_coord(min_y_ext, half_pos);
   assign sh_max_x_in = shift_coord(max_x_ext, half_pos);
   assign sh_max_y_in = shift_coord(max_y_ext, half_pos);

   // Stage one registers
   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         outside_ff  <= outside_in;
         sh_min_x_ff <= sh_min_x_in;
         sh_min_y_ff <= sh_min_y_in;
         sh_max_x_ff <= sh_max_x_in;
         sh_max_y_ff <= sh_max_y_in;
      end
   end

   assign outside     = outside_ff;
   assign shift_min_x = sh_min_x_ff;
   assign shift_min_y = sh_min_y_ff;
   assign shift_max_x = sh_max_x_ff;
   assign shift_max_y = sh_max_y_ff;

endmodule

[src/lqns_axis_grid.sv]
// Second and third pipeline stages for one axis: scaling of both corners onto
// the grid, floor for the minimum, ceiling for the maximum, and saturation.
// Depends on lqns_pkg.
module lqns_axis_grid
   import lqns_pkg::*;
#(
   parameter int GRID_BITS = GRID_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  pipe_ctrl_type         ctrl,
   input  logic [SCALE_W-1:0]    scale,
   input  logic [SHIFT_W-1:0]    shift_min,
   input  logic [SHIFT_W-1:0]    shift_max,
   output logic [GRID_BITS-1:0]  grid_min,
   output logic [GRID_BITS-1:0]  grid_max
);

   localparam int HI_W = PROD_W - FRAC_W;
   localparam logic [HI_W-1:0] GRID_TOP = HI_W'((1 << GRID_BITS) - 1);

   logic [PROD_W-1:0]    prod_min_in, prod_max_in, prod_min_ff, prod_max_ff;
   logic [HI_W-1:0]      hi_min, hi_max;
   logic                 frac_max_nz;
   logic [GRID_BITS-1:0] grid_min_in, grid_max_in, grid_min_ff, grid_max_ff;

   // Stage two: one multiplier per corner
   assign prod_min_in = {{SCALE_W{1'b0}}, shift_min} * {{SHIFT_W{1'b0}}, scale};
   assign prod_max_in = {{SCALE_W{1'b0}}, shift_max} * {{SHIFT_W{1'b0}}, scale};

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         prod_min_ff <= prod_min_in;
         prod_max_ff <= prod_max_in;
      end
   end

   // Stage three: round and saturate to the grid maximum
   assign hi_min      = prod_min_ff[PROD_W-1:FRAC_W];
   assign hi_max      = prod_max_ff[PROD_W-1:FRAC_W];
   assign frac_max_nz = |prod_max_ff[FRAC_W-1:0];

   always_comb begin
      if (hi_min > GRID_TOP) begin
         grid_min_in = GRID_TOP[GRID_BITS-1:0];
      end else begin
         grid_min_in = hi_min[GRID_BITS-1:0];
      end
      if ((hi_max > GRID_TOP) || ((hi_max == GRID_TOP) && frac_max_nz)) begin
         grid_max_in = GRID_TOP[GRID_BITS-1:0];
      end else begin
         grid_max_in = hi_max[GRID_BITS-1:0] + GRID_BITS'(frac_max_nz);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s3_load) begin
         grid_min_ff <= grid_min_in;
         grid_max_ff <= grid_max_in;
      end
   end

   assign grid_min = grid_min_ff;
   assign grid_max = grid_max_ff;

endmodule

[src/lqns_level.sv]
// Fourth and fifth pipeline stages: level choice from the top differing grid bit,
// then cell coordinates and absolute node index into the output register.
// Depends on lqns_pkg.
module lqns_level
   import lqns_pkg::*;
#(
   parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
   parameter int GRID_BITS   = GRID_BITS_DEFAULT
)
(
   input  logic                  clock,
   input  pipe_ctrl_type         ctrl,
   input  logic                  outside_in,
   input  logic [GRID_BITS-1:0]  grid_min_x,
   input  logic [GRID_BITS-1:0]  grid_max_x,
   input  logic [GRID_BITS-1:0]  grid_min_y,
   input  logic [GRID_BITS-1:0]  grid_max_y,
   output logic                  outside,
   output logic [LEVEL_W-1:0]    level,
   output logic [CELL_W-1:0]     cell_x,
   output logic [CELL_W-1:0]     cell_y,
   output logic [NODE_W-1:0]     node_index
);

   localparam int CW = GRID_BITS + CELL_W + 1;

   logic [LEVEL_W-1:0]   lvl_x, lvl_y, lvl_in, lvl_ff;
   logic [GRID_BITS-1:0] gx_in, gy_in, gx_ff, gy_ff;
   logic                 out4_in, out4_ff;

   logic [CW-1:0]        cell_x_wide, cell_y_wide;
   logic [CELL_W-1:0]    cx, cy;
   logic [NODE_W-1:0]    node_sum;

   logic                 outside_o_in, outside_o_ff;
   logic [LEVEL_W-1:0]   level_o_in, level_o_ff;
   logic [CELL_W-1:0]    cell_x_o_in, cell_x_o_ff, cell_y_o_in, cell_y_o_ff;
   logic [NODE_W-1:0]    node_o_in, node_o_ff;

   // Level of one axis from the top set bit of min XOR max.
   function automatic logic [LEVEL_W-1:0] axis_level(input logic [GRID_BITS-1:0] d);
      int top;
      int lvl;
      top = -1;
      for (int i = 0; i < GRID_BITS; i++) begin
         if (d[i]) top = i;
      end
      if (top < 0) lvl = LEVEL_COUNT - 1;
      else         lvl = LEVEL_COUNT - 1 - top;
      if (lvl < 0) lvl = 0;
      return LEVEL_W'(lvl);
   endfunction

   // Stage four: pick the shallower of the two axis levels
   assign lvl_x   = axis_level(grid_min_x ^ grid_max_x);
   assign lvl_y   = axis_level(grid_min_y ^ grid_max_y);
   assign lvl_in  = (lvl_x < lvl_y) ? lvl_x : lvl_y;
   assign gx_in   = grid_min_x;
   assign gy_in   = grid_min_y;
   assign out4_in = outside_in;

   always_ff @(posedge clock) begin
      if (ctrl.s4_load) begin
         lvl_ff  <= lvl_in;
         gx_ff   <= gx_in;
         gy_ff   <= gy_in;
         out4_ff <= out4_in;
      end
   end

   // Stage five: cell of the minimum corner at the chosen level. Shifting left by
   // the level and right by the grid width covers both deeper and shallower levels.
   assign cell_x_wide = (CW'(gx_ff) << lvl_ff) >> GRID_BITS;
   assign cell_y_wide = (CW'(gy_ff) << lvl_ff) >> GRID_BITS;
   assign cx          = cell_x_wide[CELL_W-1:0];
   assign cy          = cell_y_wide[CELL_W-1:0];
   assign node_sum    = level_base(lvl_ff) + (NODE_W'(cy) << lvl_ff) + NODE_W'(cx);

   // An outside box reports the root with all fields zero.
   always_comb begin
      outside_o_in = out4_ff;
      if (out4_ff) begin
         level_o_in  = '0;
         cell_x_o_in = '0;
         cell_y_o_in = '0;
         node_o_in   = '0;
      end else begin
         level_o_in  = lvl_ff;
         cell_x_o_in = cx;
         cell_y_o_in = cy;
         node_o_in   = node_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.s5_load) begin
         outside_o_ff <= outside_o_in;
         level_o_ff   <= level_o_in;
         cell_x_o_ff  <= cell_x_o_in;
         cell_y_o_ff  <= cell_y_o_in;
         node_o_ff    <= node_o_in;
      end
   end

   assign outside    = outside_o_ff;
   assign level      = level_o_ff;
   assign cell_x     = cell_x_o_ff;
   assign cell_y     = cell_y_o_ff;
   assign node_index = node_o_ff;

endmodule

[src/loose_quadtree_node_select_core.sv]
// Top level of the loose quadtree node selector: configuration registers,
// pipeline handshake control and the stage modules.
// Depends on lqns_pkg, lqns_front, lqns_axis_grid and lqns_level.
//
// Usage: each beat on the req_ channel carries one box (four signed Q16.8
// corners). For each box the rsp_ channel delivers one beat: the owning level,
// the cell column and row within it and the absolute node index in tdata, and
// the outside flag in tuser.
// From an accepted req_ beat to rsp_tvalid the stages are shift and
// bounds check, multiply, rounding, level choice, cell and node index. The
// pipeline takes one box per cycle unless rsp_tready stalls it when full; the
// corner multipliers, one 24 by 32 bit unit per corner, sit in their own stage.
// When the receiver holds rsp_tready low, each stage keeps its beat and the
// stages behind it still fill any empty slots; req_tready falls only once all
// five stages are full. Nothing is dropped or repeated.
// The csr_ port writes half_size (address 0) and scale (address 4); it is to
// be written only while no box is in flight. Reset empties the pipeline and
// returns both registers to their reset values; no clearing pass is needed.
module loose_quadtree_node_select_core
   import lqns_pkg::*;
#(
   parameter int LEVEL_COUNT = LEVEL_COUNT_DEFAULT,
   parameter int GRID_BITS   = GRID_BITS_DEFAULT
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Input boxes
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [IN_DATA_W-1:0]   req_tdata,   // min_x, min_y, max_x, max_y
   // Results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [OUT_DATA_W-1:0]  rsp_tdata,   // level, cell_x, cell_y, node_index
   output logic                   rsp_tuser,   // outside
   // Configuration
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   localparam int STAGES = 5;

   csr_reg_type         reg_sel;
   logic                csr_write;
   logic [HALF_W-1:0]   half_size_in, half_size_ff;
   logic [SCALE_W-1:0]  scale_in, scale_ff;

   logic [STAGES-1:0]   valid_in, valid_ff;
   logic [STAGES-1:0]   stage_ready;
   pipe_ctrl_type       ctrl;

   logic                outside_s1, outside_s2_in, outside_s2_ff, outside_s3_in, outside_s3_ff;
   logic [SHIFT_W-1:0]  sh_min_x, sh_min_y, sh_max_x, sh_max_y;
   logic [GRID_BITS-1:0] g_min_x, g_max_x, g_min_y, g_max_y;

   logic                res_outside;
   logic [LEVEL_W-1:0]  res_level;
   logic [CELL_W-1:0]   res_cell_x, res_cell_y;
   logic [NODE_W-1:0]   res_node;

   // Configuration registers
   assign reg_sel    = csr_reg_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      half_size_in = half_size_ff;
      scale_in     = scale_ff;
      csr_prdata   = '0;
      unique case (reg_sel)
         REG_HALF_SIZE: begin
            if (csr_write) half_size_in = csr_pwdata[HALF_W-1:0];
            csr_prdata = CSR_DATA_W'(half_size_ff);
         end
         REG_SCALE: begin
            if (csr_write) scale_in = csr_pwdata[SCALE_W-1:0];
            csr_prdata = scale_ff;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_size_ff <= HALF_SIZE_RESET;
         scale_ff     <= SCALE_RESET;
      end else begin
         half_size_ff <= half_size_in;
         scale_ff     <= scale_in;
      end
   end

   // Stage handshake: a stage loads when it is empty or its beat moves on.
   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         stage_ready[i] = !valid_ff[i] || stage_ready[i+1];
      end
      for (int i = 0; i < STAGES; i++) begin
         if (stage_ready[i]) valid_in[i] = (i == 0) ? req_tvalid : valid_ff[(i == 0) ? 0 : i-1];
         else                valid_in[i] = valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctrl.s1_load = stage_ready[0];
   assign ctrl.s2_load = stage_ready[1];
   assign ctrl.s3_load = stage_ready[2];
   assign ctrl.s4_load = stage_ready[3];
   assign ctrl.s5_load = stage_ready[4];

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // Stage one
   lqns_front u_front (
      .clock       (clock),
      .ctrl        (ctrl),
      .half_size   (half_size_ff),
      .min_x       (req_tdata[COORD_W-1:0]),
      .min_y       (req_tdata[2*COORD_W-1:COORD_W]),
      .max_x       (req_tdata[3*COORD_W-1:2*COORD_W]),
      .max_y       (req_tdata[4*COORD_W-1:3*COORD_W]),
      .outside     (outside_s1),
      .shift_min_x (sh_min_x),
      .shift_min_y (sh_min_y),
      .shift_max_x (sh_max_x),
      .shift_max_y (sh_max_y)
   );

   // The outside flag travels beside the grid stages.
   assign outside_s2_in = outside_s1;
   assign outside_s3_in = outside_s2_ff;

   always_ff @(posedge clock) begin
      if (ctrl.s2_load) outside_s2_ff <= outside_s2_in;
      if (ctrl.s3_load) outside_s3_ff <= outside_s3_in;
   end

   // Stages two and three, one lane per axis
   lqns_axis_grid #(.GRID_BITS(GRID_BITS)) u_grid_x (
      .clock     (clock),
      .ctrl      (ctrl),
      .scale     (scale_ff),
      .shift_min (sh_min_x),
      .shift_max (sh_max_x),
      .grid_min  (g_min_x),
      .grid_max  (g_max_x)
   );

   lqns_axis_grid #(.GRID_BITS(GRID_BITS)) u_grid_y (
      .clock     (clock),
      .ctrl      (ctrl),
      .scale     (scale_ff),
      .shift_min (sh_min_y),
      .shift_max (sh_max_y),
      .grid_min  (g_min_y),
      .grid_max  (g_max_y)
   );

   // Stages four and five
   lqns_level #(.LEVEL_COUNT(LEVEL_COUNT), .GRID_BITS(GRID_BITS)) u_level (
      .clock      (clock),
      .ctrl       (ctrl),
      .outside_in (outside_s3_ff),
      .grid_min_x (g_min_x),
      .grid_max_x (g_max_x),
      .grid_min_y (g_min_y),
      .grid_max_y (g_max_y),
      .outside    (res_outside),
      .level      (res_level),
      .cell_x     (res_cell_x),
      .cell_y     (res_cell_y),
      .node_index (res_node)
   );

   assign rsp_tdata = {res_node, res_cell_y, res_cell_x, res_level};
   assign rsp_tuser = res_outside;

endmodule
